// ===== rtl/hpe_pkg.sv =====
// Shared types and constants of the Horner polynomial evaluator.
// Depends on nothing; used by hpe_cell and horner_polynomial_evaluator_core.
package hpe_pkg;

    // Fixed field widths
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 64;
    localparam int NUM_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int COEF_REGS = 7;

    // Default parameter values
    localparam int DEF_MAX_TERMS = 7;
    localparam int DEF_FRAC_BITS = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TERMS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE = 3'd1;

    // Reset value of the term count
    localparam logic [NUM_W-1:0] NUM_TERMS_RST = 3'd1;

    // Data carried from cell to cell along the chain
    typedef struct packed {
        logic signed [DATA_W-1:0] acc;
        logic signed [DATA_W-1:0] x;
        logic                     ovf;
    } t_item;

endpackage

// ===== rtl/hpe_cell.sv =====
// One Horner step cell: multiply by x, round, add a coefficient, saturate.
// Two register stages per cell; uses hpe_pkg for t_item and widths.
module hpe_cell
    import hpe_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic signed [DATA_W-1:0] i_coef,
    input  logic                     i_valid,
    input  t_item                    i_item,
    output logic                     o_valid,
    output t_item                    o_item
);

    // Half an LSB of the result, zero when there are no fraction bits
    localparam logic signed [PROD_W-1:0] ROUND_BIAS =
        (PROD_W'(64'sd1) <<< FRAC_BITS) >>> 1;
    localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [PROD_W-1:0] SAT_MIN = -64'sd2147483648;

    logic                     r_a_valid;
    logic signed [PROD_W-1:0] r_a_prod;
    t_item                    r_a_item;
    logic signed [PROD_W-1:0] n_a_prod;

    logic                     r_b_valid;
    t_item                    r_b_item;
    t_item                    n_b_item;

    logic signed [PROD_W-1:0] w_coef_ext;
    logic signed [PROD_W-1:0] w_sum;
    logic signed [PROD_W-1:0] w_res;
    logic                     w_sat_hi;
    logic                     w_sat_lo;

    // Stage A: exact product of running value and x
    assign n_a_prod = i_item.acc * i_item.x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_prod <= n_a_prod;
        r_a_item <= i_item;
    end

    // Stage B: round and add the coefficient in one sum, then floor-shift.
    // Adding coef * 2^F before the shift equals adding coef after it.
    always_comb begin
        w_coef_ext = PROD_W'(i_coef) <<< FRAC_BITS;
        w_sum      = r_a_prod + ROUND_BIAS + w_coef_ext;
        w_res      = w_sum >>> FRAC_BITS;
        w_sat_hi   = (w_res > SAT_MAX);
        w_sat_lo   = (w_res < SAT_MIN);
    end

    // Clamp when the step is in use, pass the item through otherwise
    always_comb begin
        n_b_item = r_a_item;
        if (i_en) begin
            if (w_sat_hi) begin
                n_b_item.acc = SAT_MAX[DATA_W-1:0];
            end else if (w_sat_lo) begin
                n_b_item.acc = SAT_MIN[DATA_W-1:0];
            end else begin
                n_b_item.acc = w_res[DATA_W-1:0];
            end
            n_b_item.ovf = r_a_item.ovf | w_sat_hi | w_sat_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_item <= n_b_item;
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

endmodule

// ===== rtl/horner_polynomial_evaluator_core.sv =====
// Horner polynomial evaluator, signed fixed point, one item per cycle.
// Each result passes the input register and then the chain of step cells,
// each with a multiply stage and a round/add/saturate stage.
// Throughput: one item every cycle; busy stays low and results cannot stall.
// Reset (synchronous, active low) empties the chain, sets num_terms to 1 and
// clears all coefficients.  Depends on hpe_pkg and hpe_cell.
module horner_polynomial_evaluator_core
    import hpe_pkg::*;
#(
    parameter int MAX_TERMS = DEF_MAX_TERMS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] i_x_value,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_wdata,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_poly_value,
    output logic                     o_overflow
);

    localparam int LATENCY = 1 + 2 * (MAX_TERMS - 1);
    localparam logic [NUM_W-1:0] MAX_N = NUM_W'(MAX_TERMS);

    logic [NUM_W-1:0]         r_num_terms;
    logic signed [DATA_W-1:0] r_coef [COEF_REGS];
    logic [NUM_W-1:0]         w_n_eff;

    logic                     r_in_valid;
    t_item                    r_in_item;
    t_item                    n_in_item;

    logic                     w_valid [MAX_TERMS];
    t_item                    w_item  [MAX_TERMS];

    // Pipeline accepts a new item every cycle
    assign busy = 1'b0;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_terms <= NUM_TERMS_RST;
            for (int i = 0; i < COEF_REGS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NUM_TERMS: r_num_terms <= i_cfg_wdata[NUM_W-1:0];
                default:       r_coef[i_cfg_index - CFG_COEF_BASE] <= i_cfg_wdata;
            endcase
        end
    end

    // Limit the term count to the chain length
    assign w_n_eff = (r_num_terms > MAX_N) ? MAX_N : r_num_terms;

    // Input stage: load the leading coefficient, or zero for no terms
    always_comb begin
        n_in_item.acc = (w_n_eff == '0) ? '0 : r_coef[0];
        n_in_item.x   = i_x_value;
        n_in_item.ovf = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_item <= n_in_item;
    end

    assign w_valid[0] = r_in_valid;
    assign w_item[0]  = r_in_item;

    // Chain of step cells; cell k applies coefficient k when k < terms in use
    for (genvar k = 1; k < MAX_TERMS; k++) begin : g_cell
        logic w_en;
        assign w_en = (NUM_W'(k) < w_n_eff);

        hpe_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_coef  (r_coef[k]),
            .i_valid (w_valid[k-1]),
            .i_item  (w_item[k-1]),
            .o_valid (w_valid[k]),
            .o_item  (w_item[k])
        );
    end

    // Result from the end of the chain
    assign o_valid      = w_valid[MAX_TERMS-1];
    assign o_poly_value = w_item[MAX_TERMS-1].acc;
    assign o_overflow   = w_item[MAX_TERMS-1].ovf;

`ifndef SYNTH
    // Every result comes from an accepted item, delayed by the whole chain
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start & ~busy, LATENCY))
        else $error("result without a matching accepted item");

    // Every accepted item yields a result at the end of the chain
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start & ~busy) |-> ##LATENCY o_valid)
        else $error("accepted item lost in the chain");

    // With at most one term no step runs, so no saturation can occur
    a_no_step_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && w_n_eff <= NUM_W'(1)) |-> !o_overflow)
        else $error("overflow raised with no Horner step");

    // Empty polynomial evaluates to zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && w_n_eff == '0) |-> (o_poly_value == '0))
        else $error("empty polynomial gave a nonzero value");
`endif

endmodule
